/* src/kpe_pkg.sv */
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types and constants of the key press event classifier.
// ----------------------------------------------------------------------------
package kpe_pkg;

  localparam int unsigned KEY_COUNT      = 25;
  localparam int unsigned KEY_CODE_W     = 5;
  localparam int unsigned KEY_IDX_W      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned INTERVAL_W     = 16;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(125);

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HOLD     = 2'd2,
    ST_RELEASED = 2'd3
  } key_state_e;

  typedef enum logic [1:0] {
    MODE_SHORT          = 2'd0,
    MODE_SHORT_REPEATED = 2'd1,
    MODE_SHORT_OR_LONG  = 2'd2
  } repeat_mode_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } action_kind_e;

  typedef struct packed {
    logic [1:0]        prev_state;
    logic              held;
    logic [TIME_W-1:0] last_short;
  } key_entry_t;

  typedef struct packed {
    action_kind_e kind;
    logic [1:0]   next_state;
    logic         next_held;
    logic         store_time;
  } key_update_t;

endpackage

/* src/kpe_in_if.sv */
// ----------------------------------------------------------------------------
// kpe_in_if
// Request channel carrying one key report.
// ----------------------------------------------------------------------------
interface kpe_in_if;
  import kpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_CODE_W-1:0] key_code;
  logic [1:0]            key_state;
  logic [1:0]            repeat_mode;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, key_code, key_state, repeat_mode, now_ms, input ready);
  modport sink (input valid, key_code, key_state, repeat_mode, now_ms, output ready);
endinterface

/* src/kpe_out_if.sv */
// ----------------------------------------------------------------------------
// kpe_out_if
// Request channel carrying one action decision.
// ----------------------------------------------------------------------------
interface kpe_out_if;
  import kpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_CODE_W-1:0] action_key;
  logic [1:0]            action_kind;

  modport source (output valid, action_key, action_kind, input ready);
  modport sink (input valid, action_key, action_kind, output ready);
endinterface

/* src/kpe_cfg_if.sv */
// ----------------------------------------------------------------------------
// kpe_cfg_if
// Configuration write channel for the repeat interval register.
// ----------------------------------------------------------------------------
interface kpe_cfg_if;
  import kpe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/kpe_decide.sv */
// ----------------------------------------------------------------------------
// kpe_decide
// Per-report decision: action kind and next per-key state.
// ----------------------------------------------------------------------------
module kpe_decide (
  input  logic [1:0]                    key_state_i,
  input  logic [1:0]                    repeat_mode_i,
  input  logic [kpe_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [kpe_pkg::INTERVAL_W-1:0] interval_i,
  input  kpe_pkg::key_entry_t           entry_i,
  output kpe_pkg::key_update_t          update_o
);
  import kpe_pkg::*;

  logic              try_short;
  logic [TIME_W-1:0] elapsed;
  logic              interval_ok;

  assign elapsed     = now_ms_i - entry_i.last_short;
  assign interval_ok = elapsed > TIME_W'(interval_i);

  always_comb begin
    try_short           = 1'b0;
    update_o.kind       = KIND_NONE;
    update_o.next_state = key_state_i;
    update_o.next_held  = entry_i.held;
    update_o.store_time = 1'b0;
    unique case (key_state_i)
      ST_PRESSED: begin
        if ((repeat_mode_i == MODE_SHORT || repeat_mode_i == MODE_SHORT_REPEATED) &&
            entry_i.prev_state != ST_PRESSED) begin
          try_short = 1'b1;
        end
      end
      ST_HOLD: begin
        if (repeat_mode_i == MODE_SHORT_OR_LONG && entry_i.prev_state != ST_HOLD) begin
          update_o.next_held = 1'b1;
          update_o.kind      = KIND_LONG;
        end else if (repeat_mode_i == MODE_SHORT_REPEATED) begin
          try_short = 1'b1;
        end
      end
      ST_RELEASED: begin
        if (repeat_mode_i == MODE_SHORT_OR_LONG && !entry_i.held &&
            entry_i.prev_state != ST_RELEASED) begin
          try_short = 1'b1;
        end
        update_o.next_held = 1'b0;
      end
      default: begin
      end
    endcase
    if (try_short && interval_ok) begin
      update_o.kind       = KIND_SHORT;
      update_o.store_time = 1'b1;
    end
  end
endmodule

/* src/key_press_event_classifier.sv */
// ----------------------------------------------------------------------------
// key_press_event_classifier
// Classifies debounced key reports into short, long or no action per key.
// ----------------------------------------------------------------------------
// Usage: key reports enter on key_req_i, one request per report, carrying the
// key index, its debounced state, its repeat mode and the millisecond time.
// Every report yields exactly one decision request on act_req_o with the key
// index and the action kind. The minimum interval between two short actions
// of one key is written through cfg_req_i, which is always ready; write it
// only while no report is in flight.
// A report is registered at the input and its decision is registered at the
// output. One report is accepted per cycle unless the receiver stalls; the
// per-key state is updated as a report moves into the output register, so a
// report for the same key in the next cycle sees the updated state.
// When the receiver stalls, the output register holds its decision and the
// input register takes one more report before ready drops.
// Reset clears all per-key states to idle, the held flags and short-action
// times to zero, and sets the interval to 125 ms.
// ----------------------------------------------------------------------------
module key_press_event_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  kpe_cfg_if.sink     cfg_req_i,
  kpe_in_if.sink      key_req_i,
  kpe_out_if.source   act_req_o
);
  import kpe_pkg::*;

  logic [INTERVAL_W-1:0] interval_q;

  logic                  s1_valid_q;
  logic [KEY_CODE_W-1:0] s1_key_q;
  logic [1:0]            s1_state_q;
  logic [1:0]            s1_mode_q;
  logic [TIME_W-1:0]     s1_now_q;

  logic                  out_valid_q;
  logic [KEY_CODE_W-1:0] out_key_q;
  logic [1:0]            out_kind_q;

  key_entry_t            entry_q [KEY_COUNT];
  key_entry_t            entry_rd;
  key_update_t           upd;

  logic                  advance;
  logic                  in_range;
  logic [KEY_IDX_W-1:0]  idx;

  assign cfg_req_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_req_i.valid) begin
      interval_q <= cfg_req_i.data;
    end
  end

  assign advance         = s1_valid_q && (!out_valid_q || act_req_o.ready);
  assign key_req_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (key_req_i.ready) begin
      s1_valid_q <= key_req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_req_i.ready && key_req_i.valid) begin
      s1_key_q   <= key_req_i.key_code;
      s1_state_q <= key_req_i.key_state;
      s1_mode_q  <= key_req_i.repeat_mode;
      s1_now_q   <= key_req_i.now_ms;
    end
  end

  assign in_range = (KEY_IDX_W + KEY_CODE_W)'(s1_key_q) <
                    (KEY_IDX_W + KEY_CODE_W)'(KEY_COUNT);
  assign idx      = KEY_IDX_W'(s1_key_q);

  always_comb begin
    entry_rd = '0;
    if (in_range) begin
      entry_rd = entry_q[idx];
    end
  end

  kpe_decide u_decide (
    .key_state_i   (s1_state_q),
    .repeat_mode_i (s1_mode_q),
    .now_ms_i      (s1_now_q),
    .interval_i    (interval_q),
    .entry_i       (entry_rd),
    .update_o      (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        entry_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      entry_q[idx].prev_state <= upd.next_state;
      entry_q[idx].held       <= upd.next_held;
      if (upd.store_time) begin
        entry_q[idx].last_short <= s1_now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (act_req_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_key_q  <= s1_key_q;
      out_kind_q <= in_range ? upd.kind : KIND_NONE;
    end
  end

  assign act_req_o.valid       = out_valid_q;
  assign act_req_o.action_key  = out_key_q;
  assign act_req_o.action_kind = out_kind_q;
endmodule
